// ===== hw/rtl/brst_pkg.sv =====
// Shared constants and types for the block range set tracker.
`timescale 1ns / 1ps
package brst_pkg;

   localparam int MAX_RANGES = 32;
   localparam int IDX_W      = $clog2(MAX_RANGES);
   localparam int CNT_W      = $clog2(MAX_RANGES + 2);
   localparam int BLK_W      = 31;

   typedef enum logic [1:0] {
      MODE_ADD   = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_WALK  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH,
      ST_SCHK,
      ST_LRD,
      ST_LCHK,
      ST_RRD,
      ST_RCHK,
      ST_APPLY,
      ST_SHRD,
      ST_SHWR,
      ST_INS,
      ST_FINISH,
      ST_WALK,
      ST_WCHK,
      ST_WEND
   } state_type;

endpackage

// ===== hw/rtl/brst_req_if.sv =====
// Request channel: one add, query or window walk command.
`timescale 1ns / 1ps
interface brst_req_if import brst_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       mode;
   logic [BLK_W-1:0] block;
   logic [BLK_W-1:0] window_start;
   logic [BLK_W-1:0] window_end;

   modport source (output valid, mode, block, window_start, window_end, input ready);
   modport sink (input valid, mode, block, window_start, window_end, output ready);
endinterface

// ===== hw/rtl/brst_rsp_if.sv =====
// Response channel: one result of a request.
`timescale 1ns / 1ps
interface brst_rsp_if import brst_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             was_held;
   logic             range_valid;
   logic [BLK_W-1:0] range_first;
   logic [BLK_W-1:0] range_stop;
   logic             last;
   logic             table_full;
   logic [BLK_W-1:0] held_count;
   logic [BLK_W-1:0] todo_count;
   logic [5:0]       ranges_used;

   modport source (output valid, was_held, range_valid, range_first, range_stop, last,
                   table_full, held_count, todo_count, ranges_used, input ready);
   modport sink (input valid, was_held, range_valid, range_first, range_stop, last,
                 table_full, held_count, todo_count, ranges_used, output ready);
endinterface

// ===== hw/rtl/block_range_set_tracker.sv =====
// Block range set tracker: sorted range table with search, insert, merge and walk.
// All table work goes through one read and one write port of the range table, one
// entry at a time, one request at a time (req ready only when idle). A query runs a
// binary search over the stored ranges; an add follows it with reads of the left and
// right neighbors where they exist and, when a range is inserted or two ranges merge,
// a read and a write per shifted entry; a window walk reads each stored range in turn
// and waits when the response side stalls. Every result sits in an output register,
// so the next request is taken while it waits.
`timescale 1ns / 1ps
module block_range_set_tracker import brst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [BLK_W-1:0] csr_wr_data,
   brst_req_if.sink         req_bus,
   brst_rsp_if.source       rsp_bus
);

   localparam logic [BLK_W-1:0] HELD_MAX = {BLK_W{1'b1}};

   state_type        state_ff, state_in;
   logic [1:0]       mode_ff, mode_in;
   logic [BLK_W-1:0] x_ff, x_in, from_ff, from_in;
   logic [CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, nr_ff, nr_in;
   logic [BLK_W-1:0] held_ff, held_in, total_ff;
   logic             left_ff, left_in, right_ff, right_in;
   logic             hit_ff, hit_in, full_ff, full_in, up_ff, up_in;
   logic             inc_cnt_ff, inc_cnt_in, dec_cnt_ff, dec_cnt_in, inc_held_ff, inc_held_in;
   logic [BLK_W-1:0] rend_ff, rend_in;
   logic [BLK_W:0]   cur_s_ff, cur_s_in, cur_e_ff, cur_e_in;

   // range table
   logic [BLK_W-1:0] starts_mem [MAX_RANGES];
   logic [BLK_W-1:0] ends_mem [MAX_RANGES];
   logic [BLK_W-1:0] rd_s_ff, rd_e_ff;
   logic             rd_en, we_s, we_e;
   logic [IDX_W-1:0] raddr, waddr;
   logic [BLK_W-1:0] wdata_s, wdata_e;

   // output register
   logic             ov_ff, ov_in, o_held_ff, o_held_in, o_rv_ff, o_rv_in;
   logic             o_last_ff, o_last_in, o_full_ff, o_full_in;
   logic [BLK_W-1:0] o_first_ff, o_first_in, o_stop_ff, o_stop_in;
   logic [BLK_W-1:0] o_hcnt_ff, o_hcnt_in, o_todo_ff, o_todo_in;
   logic [5:0]       o_used_ff, o_used_in;
   logic             out_load;

   logic             out_free, req_acc;
   logic [CNT_W:0]   mid_sum;
   logic [CNT_W-1:0] mid_w;
   logic [BLK_W-1:0] to_clamp;
   logic [BLK_W:0]   wk_s, wk_e1;
   logic             wk_skip, wk_first, wk_trim, wk_split, do_split;
   logic [BLK_W-1:0] held_new;
   logic [CNT_W-1:0] cnt_new;

   assign out_free = !ov_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc = req_bus.valid && req_bus.ready;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (CNT_W + 1)'(1);
   assign mid_w = mid_sum[CNT_W:1];
   assign to_clamp = (req_bus.window_end >= total_ff) ? total_ff : req_bus.window_end;

   assign wk_s = {1'b0, rd_s_ff};
   assign wk_e1 = {1'b0, rd_e_ff} + (BLK_W + 1)'(1);
   assign wk_skip = (wk_s > cur_e_ff) || (rd_e_ff < from_ff);
   assign wk_first = (nr_ff == CNT_W'(1)) && (rd_s_ff <= from_ff);
   assign wk_trim = (wk_e1 >= cur_e_ff);
   assign wk_split = !wk_skip && !wk_first && !wk_trim && (nr_ff <= CNT_W'(MAX_RANGES));
   assign do_split = wk_split && out_free;

   always_comb begin
      held_new = held_ff;
      cnt_new = cnt_ff;
      if (inc_held_ff && held_ff != HELD_MAX) begin
         held_new = held_ff + BLK_W'(1);
      end
      if (inc_cnt_ff) begin
         cnt_new = cnt_ff + CNT_W'(1);
      end else if (dec_cnt_ff) begin
         cnt_new = cnt_ff - CNT_W'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (mode_type'(req_bus.mode))
                  MODE_ADD, MODE_QUERY: state_in = ST_SRCH;
                  MODE_WALK:            state_in = ST_WALK;
                  default:              state_in = ST_FINISH;
               endcase
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               state_in = ST_SCHK;
            end else if (mode_ff == MODE_QUERY) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_LRD;
            end
         end
         ST_SCHK: begin
            if (x_ff > rd_e_ff || x_ff < rd_s_ff) begin
               state_in = ST_SRCH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_LRD:  state_in = (lo_ff != '0) ? ST_LCHK : ST_RRD;
         ST_LCHK: state_in = ST_RRD;
         ST_RRD:  state_in = (lo_ff < cnt_ff) ? ST_RCHK : ST_APPLY;
         ST_RCHK: state_in = ST_APPLY;
         ST_APPLY: begin
            if (left_ff && right_ff) begin
               state_in = (lo_ff + CNT_W'(1) < cnt_ff) ? ST_SHRD : ST_FINISH;
            end else if (left_ff || right_ff || cnt_ff >= CNT_W'(MAX_RANGES)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = (lo_ff < cnt_ff) ? ST_SHRD : ST_INS;
            end
         end
         ST_SHRD: state_in = ST_SHWR;
         ST_SHWR: begin
            if (up_ff) begin
               state_in = (idx_ff == lo_ff) ? ST_INS : ST_SHRD;
            end else begin
               state_in = (idx_ff + CNT_W'(2) >= cnt_ff) ? ST_FINISH : ST_SHRD;
            end
         end
         ST_INS:    state_in = ST_FINISH;
         ST_FINISH: state_in = out_free ? ST_IDLE : ST_FINISH;
         ST_WALK:   state_in = (idx_ff < cnt_ff) ? ST_WCHK : ST_WEND;
         ST_WCHK:   state_in = (wk_split && !out_free) ? ST_WCHK : ST_WALK;
         ST_WEND:   state_in = out_free ? ST_IDLE : ST_WEND;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in = mode_ff;
      x_in = x_ff;
      from_in = from_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      idx_in = idx_ff;
      nr_in = nr_ff;
      cnt_in = cnt_ff;
      held_in = held_ff;
      left_in = left_ff;
      right_in = right_ff;
      hit_in = hit_ff;
      full_in = full_ff;
      up_in = up_ff;
      inc_cnt_in = inc_cnt_ff;
      dec_cnt_in = dec_cnt_ff;
      inc_held_in = inc_held_ff;
      rend_in = rend_ff;
      cur_s_in = cur_s_ff;
      cur_e_in = cur_e_ff;
      rd_en = 1'b0;
      raddr = '0;
      we_s = 1'b0;
      we_e = 1'b0;
      waddr = '0;
      wdata_s = rd_s_ff;
      wdata_e = rd_e_ff;
      out_load = 1'b0;
      o_held_in = 1'b0;
      o_rv_in = 1'b0;
      o_first_in = '0;
      o_stop_in = '0;
      o_last_in = 1'b0;
      o_full_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               mode_in = req_bus.mode;
               x_in = req_bus.block;
               from_in = req_bus.window_start;
               lo_in = '0;
               hi_in = cnt_ff;
               idx_in = '0;
               nr_in = CNT_W'(1);
               cur_s_in = {1'b0, req_bus.window_start};
               cur_e_in = {1'b0, to_clamp};
               left_in = 1'b0;
               right_in = 1'b0;
               hit_in = 1'b0;
               full_in = 1'b0;
               inc_cnt_in = 1'b0;
               dec_cnt_in = 1'b0;
               inc_held_in = 1'b0;
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               rd_en = 1'b1;
               raddr = mid_w[IDX_W-1:0];
               mid_in = mid_w;
            end
         end
         ST_SCHK: begin
            if (x_ff > rd_e_ff) begin
               lo_in = mid_ff + CNT_W'(1);
            end else if (x_ff < rd_s_ff) begin
               hi_in = mid_ff;
            end else begin
               hit_in = 1'b1;
            end
         end
         ST_LRD: begin
            if (lo_ff != '0) begin
               rd_en = 1'b1;
               raddr = IDX_W'(lo_ff - CNT_W'(1));
            end
         end
         ST_LCHK: left_in = ({1'b0, rd_e_ff} + (BLK_W + 1)'(1)) == {1'b0, x_ff};
         ST_RRD: begin
            if (lo_ff < cnt_ff) begin
               rd_en = 1'b1;
               raddr = lo_ff[IDX_W-1:0];
            end
         end
         ST_RCHK: begin
            right_in = {1'b0, rd_s_ff} == ({1'b0, x_ff} + (BLK_W + 1)'(1));
            rend_in = rd_e_ff;
         end
         ST_APPLY: begin
            if (left_ff && right_ff) begin
               // join the two ranges, then close the gap above
               we_e = 1'b1;
               waddr = IDX_W'(lo_ff - CNT_W'(1));
               wdata_e = rend_ff;
               dec_cnt_in = 1'b1;
               inc_held_in = 1'b1;
               up_in = 1'b0;
               idx_in = lo_ff;
            end else if (left_ff) begin
               we_e = 1'b1;
               waddr = IDX_W'(lo_ff - CNT_W'(1));
               wdata_e = x_ff;
               inc_held_in = 1'b1;
            end else if (right_ff) begin
               we_s = 1'b1;
               waddr = lo_ff[IDX_W-1:0];
               wdata_s = x_ff;
               inc_held_in = 1'b1;
            end else if (cnt_ff >= CNT_W'(MAX_RANGES)) begin
               full_in = 1'b1;
            end else begin
               inc_cnt_in = 1'b1;
               inc_held_in = 1'b1;
               up_in = 1'b1;
               idx_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_SHRD: begin
            rd_en = 1'b1;
            raddr = up_ff ? idx_ff[IDX_W-1:0] : IDX_W'(idx_ff + CNT_W'(1));
         end
         ST_SHWR: begin
            we_s = 1'b1;
            we_e = 1'b1;
            waddr = up_ff ? IDX_W'(idx_ff + CNT_W'(1)) : idx_ff[IDX_W-1:0];
            if (up_ff) begin
               idx_in = idx_ff - CNT_W'(1);
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_INS: begin
            we_s = 1'b1;
            we_e = 1'b1;
            waddr = lo_ff[IDX_W-1:0];
            wdata_s = x_ff;
            wdata_e = x_ff;
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               o_held_in = hit_ff;
               o_last_in = 1'b1;
               o_full_in = full_ff;
               held_in = held_new;
               cnt_in = cnt_new;
            end
         end
         ST_WALK: begin
            if (idx_ff < cnt_ff) begin
               rd_en = 1'b1;
               raddr = idx_ff[IDX_W-1:0];
            end
         end
         ST_WCHK: begin
            if (!(wk_split && !out_free)) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (!wk_skip) begin
               if (wk_first) begin
                  cur_s_in = wk_e1;
               end else if (wk_trim) begin
                  cur_e_in = wk_s;
               end else if (do_split) begin
                  // emit the piece below this range, keep walking above it
                  out_load = 1'b1;
                  o_rv_in = 1'b1;
                  o_first_in = cur_s_ff[BLK_W-1:0];
                  o_stop_in = rd_s_ff;
                  cur_s_in = wk_e1;
                  nr_in = nr_ff + CNT_W'(1);
               end
            end
         end
         ST_WEND: begin
            if (out_free) begin
               out_load = 1'b1;
               o_last_in = 1'b1;
               if (!(nr_ff == CNT_W'(1) && cur_s_ff >= cur_e_ff)) begin
                  o_rv_in = 1'b1;
                  o_first_in = cur_s_ff[BLK_W-1:0];
                  o_stop_in = cur_e_ff[BLK_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ov_in = ov_ff;
      if (out_load) begin
         ov_in = 1'b1;
      end else if (rsp_bus.ready) begin
         ov_in = 1'b0;
      end
      o_hcnt_in = held_in;
      o_todo_in = (total_ff > held_in) ? total_ff - held_in : '0;
      o_used_in = 6'(cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         held_ff <= '0;
         total_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         held_ff <= held_in;
         ov_ff <= ov_in;
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      x_ff <= x_in;
      from_ff <= from_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      idx_ff <= idx_in;
      nr_ff <= nr_in;
      left_ff <= left_in;
      right_ff <= right_in;
      hit_ff <= hit_in;
      full_ff <= full_in;
      up_ff <= up_in;
      inc_cnt_ff <= inc_cnt_in;
      dec_cnt_ff <= dec_cnt_in;
      inc_held_ff <= inc_held_in;
      rend_ff <= rend_in;
      cur_s_ff <= cur_s_in;
      cur_e_ff <= cur_e_in;
      if (out_load) begin
         o_held_ff <= o_held_in;
         o_rv_ff <= o_rv_in;
         o_first_ff <= o_first_in;
         o_stop_ff <= o_stop_in;
         o_last_ff <= o_last_in;
         o_full_ff <= o_full_in;
         o_hcnt_ff <= o_hcnt_in;
         o_todo_ff <= o_todo_in;
         o_used_ff <= o_used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we_s) begin
         starts_mem[waddr] <= wdata_s;
      end
      if (we_e) begin
         ends_mem[waddr] <= wdata_e;
      end
      if (rd_en) begin
         rd_s_ff <= starts_mem[raddr];
         rd_e_ff <= ends_mem[raddr];
      end
   end

   assign rsp_bus.valid = ov_ff;
   assign rsp_bus.was_held = o_held_ff;
   assign rsp_bus.range_valid = o_rv_ff;
   assign rsp_bus.range_first = o_first_ff;
   assign rsp_bus.range_stop = o_stop_ff;
   assign rsp_bus.last = o_last_ff;
   assign rsp_bus.table_full = o_full_ff;
   assign rsp_bus.held_count = o_hcnt_ff;
   assign rsp_bus.todo_count = o_todo_ff;
   assign rsp_bus.ranges_used = o_used_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RANGES))
      else $error("range count above table depth");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |-> ($past(state_ff) == ST_FINISH))
      else $error("range count changed outside finish");

   a_full_used: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && o_full_ff) |-> (o_used_ff == 6'(MAX_RANGES)))
      else $error("table full flagged on a table with room");

   a_range_flags: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && o_rv_ff) |-> (!o_held_ff && !o_full_ff))
      else $error("walk result carries add flags");

endmodule
